>>> sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the SBUS frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    localparam int TICK_COUNTER_WIDTH = 16;

    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_W       = 11;
    localparam int CH_IDX_W     = 4;
    localparam int BYTE_W       = 8;
    localparam int POS_W        = 5;
    localparam int ACC_W        = 18;
    localparam int HELD_W       = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int TIMEOUT_W    = 16;
    localparam int SUM_W        = CHAN_W + 1;
    localparam int CMP_W        = (TICK_COUNTER_WIDTH > TIMEOUT_W) ?
                                  TICK_COUNTER_WIDTH : TIMEOUT_W;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0F;
    localparam logic [BYTE_W-1:0] FOOTER_BYTE = 8'h00;
    localparam int                LOST_BIT     = 2;
    localparam int                FAILSAFE_BIT = 3;
    localparam logic [SUM_W-1:0]  DISARM_SPAN  = 12'd200;

    localparam logic [POS_W-1:0]  POS_HUNT      = 5'd0;
    localparam logic [POS_W-1:0]  POS_FIRST     = 5'd1;
    localparam logic [POS_W-1:0]  POS_LAST_DATA = 5'd22;
    localparam logic [POS_W-1:0]  POS_FLAGS     = 5'd23;
    localparam logic [POS_W-1:0]  POS_FOOTER    = 5'd24;
    localparam logic [HELD_W-1:0] HELD_BYTE     = 5'd8;
    localparam logic [HELD_W-1:0] HELD_CHAN     = 5'd11;
    localparam logic [CH_IDX_W-1:0] LAST_CH     = CH_IDX_W'(NUM_CHANNELS - 1);

    localparam logic OP_BYTE      = 1'b0;
    localparam logic OP_TICK      = 1'b1;
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STICK_MIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_OFS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_ARM        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_CHAN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_CHAN       = 3'd5;

    localparam logic [CHAN_W-1:0]    RST_STICK_MIN     = 11'd172;
    localparam logic [CHAN_W-1:0]    RST_THROTTLE_OFS  = 11'd100;
    localparam logic [CHAN_W-1:0]    RST_YAW_ARM       = 11'd1800;
    localparam logic [TIMEOUT_W-1:0] RST_LINK_TIMEOUT  = 16'd100;
    localparam logic [CH_IDX_W-1:0]  RST_THROTTLE_CHAN = 4'd2;
    localparam logic [CH_IDX_W-1:0]  RST_YAW_CHAN      = 4'd3;

    typedef struct packed {
        logic [CHAN_W-1:0]    stick_min_value;
        logic [CHAN_W-1:0]    throttle_low_offset;
        logic [CHAN_W-1:0]    yaw_arm_threshold;
        logic [TIMEOUT_W-1:0] link_timeout_ticks;
        logic [CH_IDX_W-1:0]  throttle_channel;
        logic [CH_IDX_W-1:0]  yaw_channel;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_THR,
        ST_RD_YAW,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic lat_thr;
        logic lat_yaw;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_op;
        logic footer_ok;
        logic out_free;
        logic item_final;
    } dp_stat_t;

    typedef struct packed {
        logic                kind;
        logic [CH_IDX_W-1:0] channel_index;
        logic [CHAN_W-1:0]   channel_value;
        logic                lost_frame;
        logic                failsafe;
        logic                connected;
        logic                arm_gesture;
        logic                disarm_gesture;
        logic                last;
    } out_item_t;

endpackage

`default_nettype wire

>>> sv/sfd_if.sv
// ----------------------------------------------------------------------------
// sfd_if
// Valid/ready channels of the SBUS frame decoder: input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfd_in_if import sfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface sfd_out_if import sfd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [CH_IDX_W-1:0] channel_index;
    logic [CHAN_W-1:0]   channel_value;
    logic                lost_frame;
    logic                failsafe;
    logic                connected;
    logic                arm_gesture;
    logic                disarm_gesture;
    logic                last;

    modport source (
        output valid, output kind, output channel_index, output channel_value,
        output lost_frame, output failsafe, output connected,
        output arm_gesture, output disarm_gesture, output last,
        input  ready
    );
    modport sink (
        input  valid, input kind, input channel_index, input channel_value,
        input  lost_frame, input failsafe, input connected,
        input  arm_gesture, input disarm_gesture, input last,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/sfd_cfg.sv
// ----------------------------------------------------------------------------
// sfd_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_cfg import sfd_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wen,
    input  wire logic [CFG_IDX_W-1:0]  index,
    input  wire logic [CFG_DATA_W-1:0] data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wen)
        begin
            case (index)
                CFG_STICK_MIN:     cfg_next.stick_min_value     = data[CHAN_W-1:0];
                CFG_THROTTLE_OFS:  cfg_next.throttle_low_offset = data[CHAN_W-1:0];
                CFG_YAW_ARM:       cfg_next.yaw_arm_threshold   = data[CHAN_W-1:0];
                CFG_LINK_TIMEOUT:  cfg_next.link_timeout_ticks  = data[TIMEOUT_W-1:0];
                CFG_THROTTLE_CHAN: cfg_next.throttle_channel    = data[CH_IDX_W-1:0];
                CFG_YAW_CHAN:      cfg_next.yaw_channel         = data[CH_IDX_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_min_value     <= RST_STICK_MIN;
            cfg_reg.throttle_low_offset <= RST_THROTTLE_OFS;
            cfg_reg.yaw_arm_threshold   <= RST_YAW_ARM;
            cfg_reg.link_timeout_ticks  <= RST_LINK_TIMEOUT;
            cfg_reg.throttle_channel    <= RST_THROTTLE_CHAN;
            cfg_reg.yaw_channel         <= RST_YAW_CHAN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/sfd_ctrl.sv
// ----------------------------------------------------------------------------
// sfd_ctrl
// Controller: accepts words, sequences the stick reads and the result burst.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ctrl import sfd_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    // ticks and good footers both end in a result
                    if (stat.in_op == OP_TICK || stat.footer_ok)
                    begin
                        state_next = ST_RD_THR;
                    end
                end
            end
            ST_RD_THR:
            begin
                cmd.lat_thr = 1'b1;
                state_next  = ST_RD_YAW;
            end
            ST_RD_YAW:
            begin
                cmd.lat_yaw = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (stat.item_final)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/sfd_datapath.sv
// ----------------------------------------------------------------------------
// sfd_datapath
// Frame parser, channel stores, link timer, gesture logic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_datapath import sfd_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  cfg_t                   cfg,
    input  ctrl_cmd_t              cmd,
    output dp_stat_t               stat,
    input  wire logic              in_op,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output out_item_t              out_item
);

    localparam logic [TICK_COUNTER_WIDTH-1:0] TICK_MAX = '1;

    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    acc_next;
    logic [HELD_W-1:0]   held_reg;
    logic [HELD_W-1:0]   held_next;
    logic [CH_IDX_W-1:0] ch_cnt_reg;
    logic [CH_IDX_W-1:0] ch_cnt_next;

    logic [CHAN_W-1:0]   pend_reg [NUM_CHANNELS];
    logic [BYTE_W-1:0]   flags_reg;
    logic [CHAN_W-1:0]   comm_reg [NUM_CHANNELS];
    logic                lost_reg;
    logic                fs_reg;
    logic [TICK_COUNTER_WIDTH-1:0] ticks_reg;

    logic                kind_reg;
    logic [CH_IDX_W-1:0] item_reg;
    logic [CHAN_W-1:0]   thr_reg;
    logic [CHAN_W-1:0]   yaw_reg;
    out_item_t           out_reg;
    out_item_t           out_next;
    logic                out_valid_reg;

    logic [ACC_W-1:0]    acc_wide;
    logic [HELD_W-1:0]   held_sum;
    logic                chan_full;
    logic                in_data;
    logic                take_byte;
    logic                take_tick;
    logic                commit;
    logic                store_chan;
    logic [CH_IDX_W-1:0] rd_idx;
    logic [CHAN_W-1:0]   rd_val;
    logic [SUM_W-1:0]    low_limit;
    logic [SUM_W-1:0]    disarm_limit;
    logic                thr_low;
    logic                connected;
    logic                out_free;

    assign take_byte = cmd.take && (in_op == OP_BYTE);
    assign take_tick = cmd.take && (in_op == OP_TICK);

    // byte lands above the bits still held
    assign acc_wide  = acc_reg | (ACC_W'(in_byte) << held_reg);
    assign held_sum  = held_reg + HELD_BYTE;
    assign chan_full = held_sum >= HELD_CHAN;
    assign in_data   = (pos_reg != POS_HUNT) && (pos_reg <= POS_LAST_DATA);
    assign commit    = take_byte && stat.footer_ok;
    assign store_chan = take_byte && in_data && chan_full;

    always_comb
    begin
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        held_next   = held_reg;
        ch_cnt_next = ch_cnt_reg;
        if (take_byte)
        begin
            if (pos_reg == POS_HUNT)
            begin
                if (in_byte == HEADER_BYTE)
                begin
                    pos_next    = POS_FIRST;
                    acc_next    = '0;
                    held_next   = '0;
                    ch_cnt_next = '0;
                end
            end
            else if (in_data)
            begin
                pos_next = pos_reg + 1'b1;
                if (chan_full)
                begin
                    acc_next    = acc_wide >> CHAN_W;
                    held_next   = held_sum - HELD_CHAN;
                    ch_cnt_next = ch_cnt_reg + 1'b1;
                end
                else
                begin
                    acc_next  = acc_wide;
                    held_next = held_sum;
                end
            end
            else if (pos_reg == POS_FLAGS)
            begin
                pos_next = POS_FOOTER;
            end
            else
            begin
                pos_next  = POS_HUNT;
                acc_next  = '0;
                held_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HUNT;
            acc_reg    <= '0;
            held_reg   <= '0;
            ch_cnt_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            held_reg   <= held_next;
            ch_cnt_reg <= ch_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_chan)
        begin
            pend_reg[ch_cnt_reg] <= acc_wide[CHAN_W-1:0];
        end
        if (take_byte && pos_reg == POS_FLAGS)
        begin
            flags_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                comm_reg[i] <= '0;
            end
            lost_reg  <= 1'b0;
            fs_reg    <= 1'b0;
            ticks_reg <= '0;
        end
        else
        begin
            if (commit)
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    comm_reg[i] <= pend_reg[i];
                end
                lost_reg  <= flags_reg[LOST_BIT];
                fs_reg    <= flags_reg[FAILSAFE_BIT];
                ticks_reg <= '0;
            end
            else if (take_tick && ticks_reg != TICK_MAX)
            begin
                ticks_reg <= ticks_reg + 1'b1;
            end
        end
    end

    // single read port on the committed channels
    always_comb
    begin
        if (cmd.lat_thr)
        begin
            rd_idx = cfg.throttle_channel;
        end
        else if (cmd.lat_yaw)
        begin
            rd_idx = cfg.yaw_channel;
        end
        else
        begin
            rd_idx = item_reg;
        end
    end

    assign rd_val = comm_reg[rd_idx];

    always_ff @(posedge clk)
    begin
        if (cmd.lat_thr)
        begin
            thr_reg <= rd_val;
        end
        if (cmd.lat_yaw)
        begin
            yaw_reg <= rd_val;
        end
    end

    assign low_limit    = {1'b0, cfg.stick_min_value} + {1'b0, cfg.throttle_low_offset};
    assign disarm_limit = {1'b0, cfg.stick_min_value} + DISARM_SPAN;
    assign thr_low      = {1'b0, thr_reg} < low_limit;
    assign connected    = CMP_W'(ticks_reg) <= CMP_W'(cfg.link_timeout_ticks);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_CHANNEL;
            item_reg <= '0;
        end
        else if (cmd.take)
        begin
            kind_reg <= (in_op == OP_TICK) ? KIND_STATUS : KIND_CHANNEL;
            item_reg <= '0;
        end
        else if (cmd.load_out)
        begin
            item_reg <= item_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_next.kind           = kind_reg;
        out_next.channel_index  = (kind_reg == KIND_STATUS) ? '0 : item_reg;
        out_next.channel_value  = (kind_reg == KIND_STATUS) ? '0 : rd_val;
        out_next.lost_frame     = lost_reg;
        out_next.failsafe       = fs_reg;
        out_next.connected      = connected;
        out_next.arm_gesture    = thr_low && (yaw_reg > cfg.yaw_arm_threshold);
        out_next.disarm_gesture = thr_low && ({1'b0, yaw_reg} < disarm_limit);
        out_next.last           = stat.item_final;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    assign stat.in_op      = in_op;
    assign stat.footer_ok  = (pos_reg > POS_FLAGS) && (in_byte == FOOTER_BYTE);
    assign stat.out_free   = out_free;
    assign stat.item_final = (kind_reg == KIND_STATUS) || (item_reg == LAST_CH);

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

>>> sv/sbus_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_core
// SBUS frame decoder, 16 channels, with link timer and stick gestures.
// ----------------------------------------------------------------------------
// in_ch takes one word per byte from the UART (operation 0) or per timer
// tick (operation 1); out_ch gives channel words and status words.
// Header, payload, flag and bad footer bytes are taken and give no word. A
// tick is accepted, the throttle and yaw channels are read through the single
// read port of the channel store, then the output register is loaded. A good
// footer is accepted and the same two channels read, then one channel word
// per cycle is loaded for all 16 channels while out_ch does not stall.
// in_ch.ready is high only between items; a stall on out_ch holds the burst
// one word at a time, and the last word may sit in the output register while
// the next byte is already taken. Reset returns the parser to hunting for a
// header, clears the channels, flags and tick count, and loads the register
// defaults. Configuration is written through cfg_wen/cfg_index/cfg_data by
// the user only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module sbus_frame_decoder_core import sfd_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sfd_in_if.sink                     in_ch,
    sfd_out_if.source                  out_ch,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    out_item_t out_item;
    logic      in_ready;
    logic      out_valid;

    sfd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wen   (cfg_wen),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    sfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sfd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (in_ch.operation),
        .in_byte   (in_ch.rx_byte),
        .out_ready (out_ch.ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign in_ch.ready           = in_ready;
    assign out_ch.valid          = out_valid;
    assign out_ch.kind           = out_item.kind;
    assign out_ch.channel_index  = out_item.channel_index;
    assign out_ch.channel_value  = out_item.channel_value;
    assign out_ch.lost_frame     = out_item.lost_frame;
    assign out_ch.failsafe       = out_item.failsafe;
    assign out_ch.connected      = out_item.connected;
    assign out_ch.arm_gesture    = out_item.arm_gesture;
    assign out_ch.disarm_gesture = out_item.disarm_gesture;
    assign out_ch.last           = out_item.last;

endmodule

`default_nettype wire

>>> sv/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the SBUS frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_checker import sfd_pkg::*; (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic                out_kind,
    input wire logic [CH_IDX_W-1:0] out_index,
    input wire logic [CHAN_W-1:0]   out_value,
    input wire logic                out_last
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
        $stable(out_index) && $stable(out_value) && $stable(out_last))
        else $error("stalled output word changed");

    // status words carry no channel and close their burst
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_STATUS |->
        out_index == '0 && out_value == '0 && out_last)
        else $error("malformed status word");

    // channel burst ends exactly on the last channel
    a_burst_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_CHANNEL |-> out_last == (out_index == LAST_CH))
        else $error("last flag out of place in channel burst");

    // no new input while a burst is still being sent
    a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_CHANNEL && !out_last |-> !in_ready)
        else $error("input taken in the middle of a channel burst");

endmodule

bind sbus_frame_decoder_core sfd_checker u_sfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_index (out_ch.channel_index),
    .out_value (out_ch.channel_value),
    .out_last  (out_ch.last)
);

`default_nettype wire

>>> tb/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_scoreboard
// Watches the word channels and the register port of the SBUS frame decoder.
// It tracks frame parsing, the committed channels, the flags and the tick
// count, queues the words each input should produce, and compares every
// result word with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sfd_scoreboard import sfd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    sfd_in_if                     in_mon,
    sfd_out_if                    out_mon,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    words_pending,
    output int                    frames_done,
    output int                    results_checked
);

    cfg_t                          cfg;
    logic [POS_W-1:0]              frame_pos;
    logic [ACC_W-1:0]              bit_acc;
    int                            bits_in;
    logic [CHAN_W-1:0]             staged_ch [NUM_CHANNELS];
    logic [BYTE_W-1:0]             staged_flags;
    logic [CHAN_W-1:0]             live_ch [NUM_CHANNELS];
    logic                          live_lost;
    logic                          live_failsafe;
    logic [TICK_COUNTER_WIDTH-1:0] idle_ticks;
    out_item_t                     expected_q[$];

    int mismatches = 0;
    int pending_now = 0;
    int frames_seen = 0;
    int checked = 0;

    assign error_count     = mismatches;
    assign words_pending   = pending_now;
    assign frames_done     = frames_seen;
    assign results_checked = checked;

    // word as the block should emit it, status taken from the current state
    function automatic out_item_t result_word(logic kind, logic [CH_IDX_W-1:0] idx,
                                              logic [CHAN_W-1:0] value, logic last);
        out_item_t         w;
        logic [CHAN_W-1:0] thr;
        logic [CHAN_W-1:0] yaw;
        logic [SUM_W-1:0]  low_limit;
        logic [SUM_W-1:0]  disarm_limit;
        logic              thr_low;
        thr          = live_ch[cfg.throttle_channel];
        yaw          = live_ch[cfg.yaw_channel];
        low_limit    = {1'b0, cfg.stick_min_value} + {1'b0, cfg.throttle_low_offset};
        disarm_limit = {1'b0, cfg.stick_min_value} + DISARM_SPAN;
        thr_low      = ({1'b0, thr} < low_limit);
        w.kind           = kind;
        w.channel_index  = idx;
        w.channel_value  = value;
        w.lost_frame     = live_lost;
        w.failsafe       = live_failsafe;
        w.connected      = (CMP_W'(idle_ticks) <= CMP_W'(cfg.link_timeout_ticks));
        w.arm_gesture    = thr_low && (yaw > cfg.yaw_arm_threshold);
        w.disarm_gesture = thr_low && ({1'b0, yaw} < disarm_limit);
        w.last           = last;
        return w;
    endfunction

    task automatic compare_field(string name, logic [CHAN_W-1:0] want,
                                 logic [CHAN_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : model
        out_item_t   want;
        logic [31:0] acc;
        int          slot;
        if (!rst_n) begin
            cfg.stick_min_value     = RST_STICK_MIN;
            cfg.throttle_low_offset = RST_THROTTLE_OFS;
            cfg.yaw_arm_threshold   = RST_YAW_ARM;
            cfg.link_timeout_ticks  = RST_LINK_TIMEOUT;
            cfg.throttle_channel    = RST_THROTTLE_CHAN;
            cfg.yaw_channel         = RST_YAW_CHAN;
            frame_pos     = POS_HUNT;
            bit_acc       = '0;
            bits_in       = 0;
            staged_flags  = '0;
            live_lost     = 1'b0;
            live_failsafe = 1'b0;
            idle_ticks    = '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                staged_ch[i] = '0;
                live_ch[i]   = '0;
            end
            expected_q.delete();
        end else begin
            // result side first: anything leaving now was queued earlier
            if (out_mon.valid && out_mon.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result word with nothing expected (index %0d, value %0d)",
                           out_mon.channel_index, out_mon.channel_value);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("kind", want.kind, out_mon.kind);
                    compare_field("channel_index", want.channel_index,
                                  out_mon.channel_index);
                    compare_field("channel_value", want.channel_value,
                                  out_mon.channel_value);
                    compare_field("lost_frame", want.lost_frame, out_mon.lost_frame);
                    compare_field("failsafe", want.failsafe, out_mon.failsafe);
                    compare_field("connected", want.connected, out_mon.connected);
                    compare_field("arm_gesture", want.arm_gesture, out_mon.arm_gesture);
                    compare_field("disarm_gesture", want.disarm_gesture,
                                  out_mon.disarm_gesture);
                    compare_field("last", want.last, out_mon.last);
                end
                checked++;
            end

            if (in_mon.valid && in_mon.ready) begin
                if (in_mon.operation == OP_TICK) begin
                    if (idle_ticks != {TICK_COUNTER_WIDTH{1'b1}})
                        idle_ticks++;
                    expected_q.push_back(result_word(KIND_STATUS, '0, '0, 1'b1));
                end else if (frame_pos == POS_HUNT) begin
                    if (in_mon.rx_byte == HEADER_BYTE) begin
                        frame_pos = POS_FIRST;
                        bit_acc   = '0;
                        bits_in   = 0;
                    end
                end else if (frame_pos <= POS_LAST_DATA) begin
                    acc     = 32'(bit_acc) | (32'(in_mon.rx_byte) << bits_in);
                    bits_in = bits_in + 8;
                    // a channel is complete as soon as 11 bits are in
                    while (bits_in >= 11) begin
                        slot = (int'(frame_pos) * 8 - bits_in) / 11;
                        staged_ch[slot[CH_IDX_W-1:0]] = acc[CHAN_W-1:0];
                        acc     = acc >> 11;
                        bits_in = bits_in - 11;
                    end
                    bit_acc   = acc[ACC_W-1:0];
                    frame_pos = frame_pos + 1'b1;
                end else if (frame_pos == POS_FLAGS) begin
                    staged_flags = in_mon.rx_byte;
                    frame_pos    = POS_FOOTER;
                end else begin
                    frame_pos = POS_HUNT;
                    bit_acc   = '0;
                    bits_in   = 0;
                    if (in_mon.rx_byte == FOOTER_BYTE) begin
                        for (int i = 0; i < NUM_CHANNELS; i++)
                            live_ch[i] = staged_ch[i];
                        live_lost     = staged_flags[LOST_BIT];
                        live_failsafe = staged_flags[FAILSAFE_BIT];
                        idle_ticks    = '0;
                        for (int i = 0; i < NUM_CHANNELS; i++)
                            expected_q.push_back(result_word(KIND_CHANNEL,
                                CH_IDX_W'(i), live_ch[i], CH_IDX_W'(i) == LAST_CH));
                        frames_seen++;
                    end
                end
            end

            if (cfg_wen) begin
                case (cfg_index)
                    CFG_STICK_MIN:     cfg.stick_min_value     = cfg_data[CHAN_W-1:0];
                    CFG_THROTTLE_OFS:  cfg.throttle_low_offset = cfg_data[CHAN_W-1:0];
                    CFG_YAW_ARM:       cfg.yaw_arm_threshold   = cfg_data[CHAN_W-1:0];
                    CFG_LINK_TIMEOUT:  cfg.link_timeout_ticks  = cfg_data[TIMEOUT_W-1:0];
                    CFG_THROTTLE_CHAN: cfg.throttle_channel    = cfg_data[CH_IDX_W-1:0];
                    CFG_YAW_CHAN:      cfg.yaw_channel         = cfg_data[CH_IDX_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_now <= expected_q.size();
    end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the SBUS frame decoder core.
// Sends bytes and ticks: a short directed run, then mostly well-formed frames
// with random channels, flags and footers, mixed with ticks, stray bytes and
// cut-off frames, under several register settings and idle/stall mixes.
// Checking is done by sfd_scoreboard, which sits beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import sfd_pkg::*;

    localparam int CYCLE_LIMIT  = 2_500_000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 36;
    localparam int NUM_PHASES   = 6;

    // indexes past the register list, written to show they do nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    int words_sent = 0;
    int ticks_sent = 0;
    int config_sets = 0;

    int error_count;
    int words_pending;
    int frames_done;
    int results_checked;

    cfg_t cur_cfg;

    sfd_in_if  in_ch ();
    sfd_out_if out_ch ();

    sbus_frame_decoder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfd_scoreboard u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_mon          (in_ch),
        .out_mon         (out_ch),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .words_pending   (words_pending),
        .frames_done     (frames_done),
        .results_checked (results_checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_word(input logic op, input logic [BYTE_W-1:0] data);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.operation <= 1'($urandom);
            in_ch.rx_byte   <= 8'($urandom);
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.rx_byte   <= data;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
        if (op == OP_TICK)
            ticks_sent++;
    endtask

    task automatic send_frame(input logic [NUM_CHANNELS*CHAN_W-1:0] payload,
                              input logic [BYTE_W-1:0] flags,
                              input logic [BYTE_W-1:0] footer, input int tick_pct);
        send_word(OP_BYTE, HEADER_BYTE);
        for (int k = 0; k < NUM_CHANNELS * CHAN_W / BYTE_W; k++)
        begin
            if ($urandom_range(99) < tick_pct)
                send_word(OP_TICK, 8'($urandom));
            send_word(OP_BYTE, payload[k*BYTE_W +: BYTE_W]);
        end
        send_word(OP_BYTE, flags);
        send_word(OP_BYTE, footer);
    endtask

    // channel values leaning toward the gesture limits of the current setting
    function automatic logic [CHAN_W-1:0] pick_channel();
        int base;
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: base = cur_cfg.stick_min_value + cur_cfg.throttle_low_offset;
            3: base = cur_cfg.yaw_arm_threshold;
            4: base = cur_cfg.stick_min_value + 200;
            5, 6: return CHAN_W'($urandom_range(0, 400));
            7: return CHAN_W'($urandom_range(1600, 2047));
            default: return CHAN_W'($urandom);
        endcase
        base = base + int'($urandom_range(0, 4)) - 2;
        if (base < 0)
            base = 0;
        if (base > 2047)
            base = 2047;
        return CHAN_W'(base);
    endfunction

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // upper bits above each register width are filled with noise
    task automatic write_config(input cfg_t c);
        put_reg(CFG_STICK_MIN, {5'($urandom), c.stick_min_value});
        put_reg(CFG_THROTTLE_OFS, {5'($urandom), c.throttle_low_offset});
        put_reg(CFG_YAW_ARM, {5'($urandom), c.yaw_arm_threshold});
        put_reg(CFG_LINK_TIMEOUT, c.link_timeout_ticks);
        put_reg(CFG_THROTTLE_CHAN, {12'($urandom), c.throttle_channel});
        put_reg(CFG_YAW_CHAN, {12'($urandom), c.yaw_channel});
        put_reg(CFG_SPARE_LO, 16'($urandom));
        put_reg(CFG_SPARE_HI, 16'($urandom));
        cfg_wen <= 1'b0;
        cur_cfg = c;
        config_sets++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_traffic(input int n_items);
        int                              start;
        int                              noise;
        int                              pick;
        logic [NUM_CHANNELS*CHAN_W-1:0]  payload;
        logic [BYTE_W-1:0]               footer;
        start = words_sent;
        noise = 0;
        while (words_sent - start - noise < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                    payload[i*CHAN_W +: CHAN_W] = pick_channel();
                footer = ($urandom_range(99) < 85) ? FOOTER_BYTE
                                                   : BYTE_W'($urandom_range(1, 255));
                send_frame(payload, 8'($urandom), footer, 4);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 8)) send_word(OP_TICK, 8'($urandom));
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 3))
                begin
                    send_word(OP_BYTE, 8'($urandom));
                    noise++;
                end
            end else begin
                // cut-off frame: the next frame's bytes run into it
                send_word(OP_BYTE, HEADER_BYTE);
                repeat ($urandom_range(1, 23)) send_word(OP_BYTE, 8'($urandom));
            end
        end
    endtask

    initial
    begin
        cfg_t next_cfg;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_BYTE;
        in_ch.rx_byte   <= '0;
        cfg_wen         <= 1'b0;
        cfg_index       <= CFG_STICK_MIN;
        cfg_data        <= '0;
        cur_cfg = '{stick_min_value: RST_STICK_MIN, throttle_low_offset: RST_THROTTLE_OFS,
                    yaw_arm_threshold: RST_YAW_ARM, link_timeout_ticks: RST_LINK_TIMEOUT,
                    throttle_channel: RST_THROTTLE_CHAN, yaw_channel: RST_YAW_CHAN};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: dropped bytes while hunting, a tick on reset state,
        // a frame of all-ones channels and flags, then another tick
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_TICK, 8'hFF);
        send_frame('1, 8'hFF, FOOTER_BYTE, 0);
        send_word(OP_TICK, 8'h00);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            next_cfg = cur_cfg;
            case (p)
                0: ;
                1: next_cfg = '{stick_min_value: '0, throttle_low_offset: '0,
                                yaw_arm_threshold: '0, link_timeout_ticks: '0,
                                throttle_channel: '0, yaw_channel: '1};
                2: next_cfg = '{stick_min_value: '1, throttle_low_offset: '1,
                                yaw_arm_threshold: '1, link_timeout_ticks: 16'd65534,
                                throttle_channel: '1, yaw_channel: '0};
                3: next_cfg = '{stick_min_value: CHAN_W'($urandom_range(0, 400)),
                                throttle_low_offset: CHAN_W'($urandom),
                                yaw_arm_threshold: CHAN_W'($urandom_range(1200, 2047)),
                                link_timeout_ticks: TIMEOUT_W'($urandom_range(0, 20)),
                                throttle_channel: CH_IDX_W'($urandom),
                                yaw_channel: CH_IDX_W'($urandom)};
                4: next_cfg = '{stick_min_value: 11'd172, throttle_low_offset: 11'd1900,
                                yaw_arm_threshold: 11'd1000, link_timeout_ticks: 16'd3,
                                throttle_channel: 4'd7, yaw_channel: 4'd7};
                default: next_cfg = '{stick_min_value: CHAN_W'($urandom),
                                      throttle_low_offset: CHAN_W'($urandom),
                                      yaw_arm_threshold: CHAN_W'($urandom),
                                      link_timeout_ticks: TIMEOUT_W'($urandom_range(0, 12)),
                                      throttle_channel: CH_IDX_W'($urandom),
                                      yaw_channel: CH_IDX_W'($urandom)};
            endcase
            if (p != 0)
                write_config(next_cfg);
            run_traffic(PHASE_ITEMS);
        end

        drain();

        $display("summary: %0d input words (%0d ticks), %0d frames committed, %0d results checked",
                 words_sent, ticks_sent, frames_done, results_checked);
        $display("summary: %0d register settings incl. reset values and both extremes",
                 config_sets + 1);
        if (error_count == 0 && words_pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> filelist.f
sv/sfd_pkg.sv
sv/sfd_if.sv
sv/sfd_cfg.sv
sv/sfd_ctrl.sv
sv/sfd_datapath.sv
sv/sbus_frame_decoder_core.sv
sv/sfd_checker.sv
tb/sfd_checker.sv
tb/testbench.sv
